// ===== hdl/cwt_pkg.sv =====
// Shared constants, codes and types of the connectivity witness transformer.
// Stand-alone package; used by connectivity_witness_transformer.

package cwt_pkg;

   localparam int LABELS  = 8;
   localparam int LABEL_W = 3;
   localparam int ROOTS_W = LABELS * LABEL_W;

   localparam logic [1:0] CMD_INTRO_VERTEX = 2'd0;
   localparam logic [1:0] CMD_INTRO_EDGE   = 2'd1;
   localparam logic [1:0] CMD_FORGET       = 2'd2;
   localparam logic [1:0] CMD_JOIN         = 2'd3;

   localparam logic [1:0] TAG_EMPTY     = 2'd0;
   localparam logic [1:0] TAG_OPEN      = 2'd1;
   localparam logic [1:0] TAG_CONNECTED = 2'd2;
   localparam logic [1:0] TAG_BROKEN    = 2'd3;

   localparam logic [1:0] ERR_OK      = 2'd0;
   localparam logic [1:0] ERR_MISSING = 2'd1;
   localparam logic [1:0] ERR_PRESENT = 2'd2;

   typedef logic [LABELS-1:0] row_type;
   // bit k of row l: labels l and k share a cell
   typedef row_type [LABELS-1:0] mat_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [LABEL_W-1:0] label_a;
      logic [LABEL_W-1:0] label_b;
      logic [1:0]         tag_first;
      logic [LABELS-1:0]  members_first;
      logic [ROOTS_W-1:0] roots_first;
      logic [1:0]         tag_second;
      logic [LABELS-1:0]  members_second;
      logic [ROOTS_W-1:0] roots_second;
   } req_type;

   typedef struct packed {
      logic [1:0]         tag;
      logic [LABELS-1:0]  mem_full;
      logic [LABELS-1:0]  mem_out;
      logic [LABEL_W-1:0] label;
      logic               forget;
      logic [1:0]         err;
   } ctl_type;

   // One squaring step of the reachability relation; the relation is symmetric,
   // so column j equals row j.
   function automatic mat_type square(input mat_type m);
      mat_type r;
      for (int i = 0; i < LABELS; i++) begin
         for (int j = 0; j < LABELS; j++) begin
            r[i][j] = |(m[i] & m[j]);
         end
      end
      return r;
   endfunction

endpackage

// ===== hdl/connectivity_witness_transformer.sv =====
// Connectivity witness transformer: pipelined partition closure and encoding.
// Depends on cwt_pkg (codes, types, squaring function).
//
//   channel  | direction | handshake             | payload
//   req_     | in        | req_tvalid/req_tready | tuser command, tdata witnesses
//   rsp_     | out       | rsp_tvalid/rsp_tready | tdata result witness and status
//
// One item per cycle while rsp_ does not stall. The input register loads at the
// accepting edge; an item then passes the link-building register, the three
// squaring stages of the cell closure and the root-encoding register in turn.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall on rsp_ freezes every stage at once, so no item is lost or repeated.

module connectivity_witness_transformer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tuser: command[1:0]
   input  logic [1:0]  req_tuser,
   // tdata: label_a[2:0], label_b[5:3], tag_first[7:6], members_first[15:8],
   //        roots_first[39:16], tag_second[41:40], members_second[49:42],
   //        roots_second[73:50], zero[79:74]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: tag_out[1:0], members_out[9:2], roots_out[33:10], final_flag[34],
   //        error_code[36:35], zero[39:37]
   output logic [39:0] rsp_tdata
);

   localparam int L  = cwt_pkg::LABELS;
   localparam int LW = cwt_pkg::LABEL_W;
   localparam int RW = cwt_pkg::ROOTS_W;
   localparam int NSTG = 4;

   logic advance;

   logic             s0_vld_ff;
   cwt_pkg::req_type s0_req_ff;
   cwt_pkg::req_type s0_req_in;

   logic             vld_ff [1:NSTG];
   cwt_pkg::mat_type mat_ff [1:NSTG];
   cwt_pkg::ctl_type ctl_ff [1:NSTG];
   cwt_pkg::mat_type adj_in;
   cwt_pkg::ctl_type ctl_in;

   logic              out_vld_ff;
   logic [1:0]        tag_out_ff, tag_out_in;
   logic [L-1:0]      mem_out_ff, mem_out_in;
   logic [RW-1:0]     roots_out_ff, roots_out_in;
   logic              final_ff, final_in;
   logic [1:0]        err_ff, err_in;

   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      s0_req_in.command        = req_tuser;
      s0_req_in.label_a        = req_tdata[2:0];
      s0_req_in.label_b        = req_tdata[5:3];
      s0_req_in.tag_first      = req_tdata[7:6];
      s0_req_in.members_first  = req_tdata[15:8];
      s0_req_in.roots_first    = req_tdata[39:16];
      s0_req_in.tag_second     = req_tdata[41:40];
      s0_req_in.members_second = req_tdata[49:42];
      s0_req_in.roots_second   = req_tdata[73:50];
   end

   // Build links and the per-command control word.
   always_comb begin
      logic [L-1:0]  m1, m2, bit_a;
      logic [LW-1:0] r;
      logic [1:0]    t1, t2;
      logic          pa, pb, join_links;
      m1    = s0_req_ff.members_first;
      m2    = s0_req_ff.members_second;
      t1    = s0_req_ff.tag_first;
      t2    = s0_req_ff.tag_second;
      bit_a = L'(1) << s0_req_ff.label_a;
      pa    = m1[s0_req_ff.label_a];
      pb    = m1[s0_req_ff.label_b];
      join_links = 1'b0;

      ctl_in.tag      = t1;
      ctl_in.mem_full = m1;
      ctl_in.label    = s0_req_ff.label_a;
      ctl_in.forget   = 1'b0;
      ctl_in.err      = cwt_pkg::ERR_OK;

      unique case (s0_req_ff.command)
         cwt_pkg::CMD_INTRO_VERTEX: begin
            if (pa) begin
               ctl_in.err = cwt_pkg::ERR_PRESENT;
            end else begin
               ctl_in.mem_full = m1 | bit_a;
               ctl_in.tag      = t1 | cwt_pkg::TAG_OPEN;
            end
         end
         cwt_pkg::CMD_INTRO_EDGE: begin
            if (pa ^ pb) ctl_in.err = cwt_pkg::ERR_MISSING;
         end
         cwt_pkg::CMD_FORGET: begin
            if (!pa) ctl_in.err = cwt_pkg::ERR_MISSING;
            else ctl_in.forget = 1'b1;
         end
         cwt_pkg::CMD_JOIN: begin
            if (t1 == cwt_pkg::TAG_EMPTY && t2 == cwt_pkg::TAG_EMPTY) begin
               ctl_in.mem_full = '0;
               ctl_in.tag      = cwt_pkg::TAG_EMPTY;
            end else begin
               join_links      = 1'b1;
               ctl_in.mem_full = m1 | m2;
               if (t1 <= cwt_pkg::TAG_OPEN && t2 <= cwt_pkg::TAG_OPEN)
                  ctl_in.tag = cwt_pkg::TAG_OPEN;
               else if ((t1 == cwt_pkg::TAG_EMPTY && t2 == cwt_pkg::TAG_CONNECTED) ||
                        (t1 == cwt_pkg::TAG_CONNECTED && t2 == cwt_pkg::TAG_EMPTY))
                  ctl_in.tag = cwt_pkg::TAG_CONNECTED;
               else
                  ctl_in.tag = cwt_pkg::TAG_BROKEN;
            end
         end
         default: ;
      endcase
      ctl_in.mem_out = ctl_in.forget ? (ctl_in.mem_full & ~bit_a) : ctl_in.mem_full;

      adj_in = '0;
      for (int l = 0; l < L; l++) begin
         r = s0_req_ff.roots_first[l*LW +: LW];
         if (m1[l] && m1[r] && (s0_req_ff.command != cwt_pkg::CMD_JOIN || join_links)) begin
            adj_in[l][r] = 1'b1;
            adj_in[r][l] = 1'b1;
         end
         r = s0_req_ff.roots_second[l*LW +: LW];
         if (join_links && m2[l] && m2[r]) begin
            adj_in[l][r] = 1'b1;
            adj_in[r][l] = 1'b1;
         end
      end
      if (s0_req_ff.command == cwt_pkg::CMD_INTRO_EDGE && pa && pb) begin
         adj_in[s0_req_ff.label_a][s0_req_ff.label_b] = 1'b1;
         adj_in[s0_req_ff.label_b][s0_req_ff.label_a] = 1'b1;
      end
      for (int l = 0; l < L; l++) adj_in[l][l] = ctl_in.mem_full[l];
   end

   // Canonical roots, cell counts and the forget tag rule.
   always_comb begin
      cwt_pkg::mat_type m;
      cwt_pkg::ctl_type c;
      logic [L-1:0]  first_full, first_out, low, row;
      logic [LW-1:0] k;
      logic          single;
      m = mat_ff[NSTG];
      c = ctl_ff[NSTG];
      roots_out_in = '0;
      for (int l = 0; l < L; l++) begin
         low = '0;
         for (int j = 0; j < l; j++) low[j] = 1'b1;
         first_full[l] = c.mem_full[l] && !(|(m[l] & c.mem_full & low));
         first_out[l]  = c.mem_out[l] && !(|(m[l] & c.mem_out & low));
         row = m[l] & c.mem_out;
         k = '0;
         for (int j = L - 1; j >= 0; j--) begin
            if (row[j]) k = LW'(j);
         end
         if (c.mem_out[l]) roots_out_in[l*LW +: LW] = k;
      end
      single = (m[c.label] & c.mem_full & ~(L'(1) << c.label)) == '0;
      tag_out_in = c.tag;
      if (c.forget && single && c.tag == cwt_pkg::TAG_OPEN) begin
         // more than one cell before the vertex vanishes: the rest is cut off
         tag_out_in = ((first_full & (first_full - L'(1))) != '0) ?
                      cwt_pkg::TAG_BROKEN : cwt_pkg::TAG_CONNECTED;
      end
      mem_out_in = c.mem_out;
      err_in     = c.err;
      final_in   = (tag_out_in != cwt_pkg::TAG_BROKEN) &&
                   ((first_out & (first_out - L'(1))) == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int s = 1; s <= NSTG; s++) vld_ff[s] <= 1'b0;
      end else if (advance) begin
         s0_vld_ff  <= req_tvalid;
         vld_ff[1]  <= s0_vld_ff;
         for (int s = 2; s <= NSTG; s++) vld_ff[s] <= vld_ff[s-1];
         out_vld_ff <= vld_ff[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_req_ff <= s0_req_in;
         mat_ff[1] <= adj_in;
         ctl_ff[1] <= ctl_in;
         for (int s = 2; s <= NSTG; s++) begin
            mat_ff[s] <= cwt_pkg::square(mat_ff[s-1]);
            ctl_ff[s] <= ctl_ff[s-1];
         end
         tag_out_ff   <= tag_out_in;
         mem_out_ff   <= mem_out_in;
         roots_out_ff <= roots_out_in;
         final_ff     <= final_in;
         err_ff       <= err_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000, err_ff, final_ff, roots_out_ff, mem_out_ff, tag_out_ff};

   // Every present label points at a present root no larger than itself.
   logic roots_ok;
   always_comb begin
      logic [LW-1:0] r;
      roots_ok = 1'b1;
      for (int l = 0; l < L; l++) begin
         r = roots_out_ff[l*LW +: LW];
         if (!mem_out_ff[l]) begin
            if (r != '0) roots_ok = 1'b0;
         end else if (r > LW'(l) || !mem_out_ff[r]) begin
            roots_ok = 1'b0;
         end
      end
   end

   a_roots_canonical: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> roots_ok)
      else $error("result roots not canonical");

   a_broken_not_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && tag_out_ff == cwt_pkg::TAG_BROKEN |-> !final_ff)
      else $error("broken witness marked final");

   // an empty partition is final unless the tag is broken
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mem_out_ff == '0 |->
         roots_out_ff == '0 && final_ff == (tag_out_ff != cwt_pkg::TAG_BROKEN))
      else $error("empty partition encoded wrongly");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> err_ff != 2'd3)
      else $error("reserved error code");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff[NSTG]) && $stable(s0_vld_ff) && $stable(ctl_ff[NSTG]))
      else $error("pipeline moved during stall");

endmodule
